>>> rtl/core/ase_pkg.sv
// shared types and constants of the ascending sort engine
package ase_pkg;

	localparam int WORD_W    = 32;
	localparam int DEPTH_DEF = 64;

	// one input word: element and end-of-run mark
	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     is_last;
	} in_word_t;

	// one output word: sorted element with run markers
	typedef struct packed {
		logic signed [WORD_W-1:0] sorted_value;
		logic                     end_of_run;
		logic                     overflow;
	} out_word_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

endpackage

>>> rtl/core/ase_cell.sv
// one cell of the sorting chain: holds an element and trades with its neighbors
module ase_cell import ase_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic signed [WORD_W-1:0] x,
	input  logic                     less_prev,
	input  logic signed [WORD_W-1:0] val_prev,
	input  logic                     occ_prev,
	input  logic signed [WORD_W-1:0] val_next,
	input  logic                     occ_next,
	output logic signed [WORD_W-1:0] val,
	output logic                     occ,
	output logic                     less
);

	logic signed [WORD_W-1:0] val_q;
	logic                     occ_q;

	// empty cells behave as +infinity
	assign less = !occ_q || (x < val_q);
	assign val  = val_q;
	assign occ  = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.shift) begin
			occ_q <= occ_next;
		end else if (ctl.insert && less) begin
			occ_q <= less_prev ? occ_prev : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= val_next;
		end else if (ctl.insert && less) begin
			val_q <= less_prev ? val_prev : x;
		end
	end

endmodule

>>> rtl/core/ascending_sort_engine.sv
// top level of the ascending sort engine: control and the chain of sorting cells
// load: one word per cycle unless stalled, sorted into the whole chain in that cycle
// the first sorted word is offered the cycle after the last input word is taken
// drain: one word per cycle from the head cell unless stalled; chain shifts toward it
// input is stalled from the last input word until the last output word is taken
// reset clears cell occupancy, the drain state and the overflow flag
module ascending_sort_engine import ase_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_word_t  src_word,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_word_t dst_word
);

	// chain taps, one per cell
	logic signed [WORD_W-1:0] val_w  [DEPTH];
	logic                     occ_w  [DEPTH];
	logic                     less_w [DEPTH];

	logic      draining_q;  // run complete, emitting sorted words
	logic      dropped_q;   // a word of this run found the store full
	logic      src_take;
	logic      dst_take;
	logic      full;
	cell_ctl_t ctl;

	// the tail cell is occupied only when every cell is
	assign full      = occ_w[DEPTH-1];
	assign src_stall = draining_q;
	assign src_take  = src_valid && !src_stall;
	assign dst_valid = draining_q && occ_w[0];
	assign dst_take  = dst_valid && !dst_stall;

	assign ctl.insert = src_take && !full;
	assign ctl.shift  = dst_take;

	// head cell holds the smallest element; the run ends when the next cell is empty
	assign dst_word.sorted_value = val_w[0];
	assign dst_word.end_of_run   = !occ_w[1];
	assign dst_word.overflow     = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else begin
			if (src_take && full) begin
				dropped_q <= 1'b1;
			end
			if (src_take && src_word.is_last) begin
				draining_q <= 1'b1;
			end
			// last word of the run leaves: ready for the next run
			if (dst_take && dst_word.end_of_run) begin
				draining_q <= 1'b0;
				dropped_q  <= 1'b0;
			end
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                     less_prev;
			logic signed [WORD_W-1:0] val_prev;
			logic                     occ_prev;
			logic signed [WORD_W-1:0] val_next;
			logic                     occ_next;

			// head cell always takes the new word itself when it is displaced
			if (i == 0) begin : g_head
				assign less_prev = 1'b0;
				assign val_prev  = '0;
				assign occ_prev  = 1'b0;
			end else begin : g_body
				assign less_prev = less_w[i-1];
				assign val_prev  = val_w[i-1];
				assign occ_prev  = occ_w[i-1];
			end

			// tail cell fills with empty during drain
			if (i == DEPTH-1) begin : g_tail
				assign val_next = '0;
				assign occ_next = 1'b0;
			end else begin : g_link
				assign val_next = val_w[i+1];
				assign occ_next = occ_w[i+1];
			end

			ase_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.x         (src_word.value),
				.less_prev (less_prev),
				.val_prev  (val_prev),
				.occ_prev  (occ_prev),
				.val_next  (val_next),
				.occ_next  (occ_next),
				.val       (val_w[i]),
				.occ       (occ_w[i]),
				.less      (less_w[i])
			);
		end
	endgenerate

endmodule

>>> rtl/core/ase_checker.sv
// port-level checks of the ascending sort engine and their bind
module ase_checker import ase_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      src_valid,
	input logic      src_stall,
	input in_word_t  src_word,
	input logic      dst_valid,
	input logic      dst_stall,
	input out_word_t dst_word
);

	// stalled output word holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_word))
		else $error("output word changed under stall");

	// a taken last word always starts a drain
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall && src_word.is_last |=> dst_valid)
		else $error("no output after end of run");

	// no input is taken while draining
	a_no_load_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> src_stall)
		else $error("input open while draining");

	// inside a run the words ascend and share one overflow flag
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && !dst_word.end_of_run |=>
			dst_valid && (dst_word.overflow == $past(dst_word.overflow)) &&
			(dst_word.sorted_value >= $past(dst_word.sorted_value)))
		else $error("run out of order or flag changed");

	// nothing follows the end of a run
	a_run_closes: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && dst_word.end_of_run |=> !dst_valid)
		else $error("output after end of run");

endmodule

bind ascending_sort_engine ase_checker u_ase_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_word  (src_word),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.dst_word  (dst_word)
);

>>> sim/ascending_sort_engine_tb.sv
// self-checking testbench of the ascending sort engine: directed runs, random runs, overflow
module ascending_sort_engine_tb;
	import ase_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int LONG_HOLD   = 300;   // receiver hold-off that backs the block up
	localparam int TAIL_CYCLES = 10;    // idle wait at the end before the owed words are checked
	localparam int PHASE_WORDS = 20;    // random words per idling phase

	localparam logic signed [WORD_W-1:0] MAX_S = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] MIN_S = 32'sh8000_0000;

	// one row of the directed table: the input word, and a hand-written result where
	// a single-element run makes it obvious
	typedef struct packed {
		in_word_t  word;
		logic      known;
		out_word_t typed;
	} stim_row_t;

	localparam int NUM_DIRECTED = 21;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		// single-element runs at the extremes of the value range, zero and minus one
		'{{MAX_S, 1'b1}, 1'b1, {MAX_S, 1'b1, 1'b0}},
		'{{MIN_S, 1'b1}, 1'b1, {MIN_S, 1'b1, 1'b0}},
		'{{32'sd0, 1'b1}, 1'b1, {32'sd0, 1'b1, 1'b0}},
		'{{-32'sd1, 1'b1}, 1'b1, {-32'sd1, 1'b1, 1'b0}},
		// two elements in reverse order
		'{{32'sd1, 1'b0}, 1'b0, '0},
		'{{32'sd0, 1'b1}, 1'b0, '0},
		// mixed signs, both extremes and a repeated value
		'{{32'sd5, 1'b0}, 1'b0, '0},
		'{{-32'sd3, 1'b0}, 1'b0, '0},
		'{{MIN_S, 1'b0}, 1'b0, '0},
		'{{MAX_S, 1'b0}, 1'b0, '0},
		'{{-32'sd3, 1'b0}, 1'b0, '0},
		'{{32'sd0, 1'b1}, 1'b0, '0},
		// already ascending
		'{{-32'sd2, 1'b0}, 1'b0, '0},
		'{{-32'sd1, 1'b0}, 1'b0, '0},
		'{{32'sd1, 1'b0}, 1'b0, '0},
		'{{32'sd2, 1'b1}, 1'b0, '0},
		// alternating bit patterns and half-word patterns
		'{{32'shAAAA_AAAA, 1'b0}, 1'b0, '0},
		'{{32'sh5555_5555, 1'b0}, 1'b0, '0},
		'{{32'sh0000_FFFF, 1'b0}, 1'b0, '0},
		'{{32'shFFFF_0000, 1'b1}, 1'b0, '0},
		// a lone pair of equal values is covered by random runs, this one closes the table
		'{{32'sd7, 1'b1}, 1'b1, {32'sd7, 1'b1, 1'b0}}
	};

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// block ports, known from time zero
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_word_t  src_word  = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	out_word_t dst_word;

	ascending_sort_engine #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word)
	);

	// idling percentages, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// long receiver hold, asked for by the stimulus and counted by the receiver
	bit long_hold_req = 1'b0;
	int hold_left     = 0;
	int holds_done    = 0;

	// bookkeeping for the summary
	int errors        = 0;
	int words_sent    = 0;
	int words_checked = 0;
	int runs_sent     = 0;
	int overflow_runs = 0;
	int longest_run   = 0;
	int idle_cycles   = 0;

	// sorter state as the block should hold it
	logic signed [WORD_W-1:0] run_store [DEPTH];
	int        run_count   = 0;
	bit        run_dropped = 1'b0;
	out_word_t run_sorted [$];       // results caused by the latest accepted word
	out_word_t sorted_expected [$];  // sorted words still owed by the block

	// take one accepted word into the run; on the last word, sort the stored
	// elements ascending as signed values and lay out the words to come
	function automatic void sorter_take(in_word_t w);
		int vals [DEPTH];
		int n;
		int j;
		int key;
		out_word_t o;
		run_sorted.delete();
		if (run_count < DEPTH) begin
			run_store[run_count] = w.value;
			run_count++;
		end else begin
			run_dropped = 1'b1;  // store full: the word is lost, last one included
		end
		if (!w.is_last)
			return;
		n = run_count;
		for (int i = 0; i < n; i++)
			vals[i] = run_store[i];
		// insertion sort, strict compare keeps equal values in arrival order
		for (int i = 1; i < n; i++) begin
			key = vals[i];
			j   = i - 1;
			while (j >= 0 && vals[j] > key) begin
				vals[j + 1] = vals[j];
				j--;
			end
			vals[j + 1] = key;
		end
		for (int i = 0; i < n; i++) begin
			o.sorted_value = vals[i];
			o.end_of_run   = (i == n - 1);
			o.overflow     = run_dropped;
			run_sorted.push_back(o);
		end
		if (run_dropped)
			overflow_runs++;
		if (n > longest_run)
			longest_run = n;
		run_count   = 0;
		run_dropped = 1'b0;
	endfunction

	function automatic void flag_mismatch(string field, logic signed [WORD_W-1:0] want,
			logic signed [WORD_W-1:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endfunction

	// offer one word, hold it until taken, then predict what it causes
	task automatic offer_word(input in_word_t w, input logic known, input out_word_t typed);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_word  <= w;
		do
			@(posedge clk);
		while (src_stall);
		sorter_take(w);
		if (known)
			sorted_expected.push_back(typed);
		else
			foreach (run_sorted[i])
				sorted_expected.push_back(run_sorted[i]);
		words_sent++;
	endtask

	// one run of random elements, marked last on its final word
	task automatic send_run(input int len);
		in_word_t w;
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: w.value = $urandom;
				6, 7:             w.value = $urandom_range(0, 8) - 4;  // near zero, repeats
				8:                w.value = MAX_S;
				default:          w.value = MIN_S;
			endcase
			w.is_last = (k == len - 1);
			offer_word(w, 1'b0, '0);
		end
		runs_sent++;
	endtask

	// hold the sender until every sorted word owed has come out
	task automatic wait_drained;
		src_valid <= 1'b0;
		while (sorted_expected.size() != 0)
			@(posedge clk);
	endtask

	// one idling phase: a run of given length at or past the store boundary first, then
	// mostly short runs with now and then a long one
	task automatic run_phase(input int send_pct, input int recv_pct, input int first_len,
			input bit with_hold);
		int start_words;
		int len;
		int r;
		bit held;
		start_words   = words_sent;
		held          = 1'b0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		send_run(first_len);
		while (words_sent - start_words < PHASE_WORDS + first_len) begin
			// receiver backs off while the sender keeps offering words
			if (with_hold && !held && words_sent - start_words >= first_len) begin
				long_hold_req = 1'b1;
				held          = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 75)
				len = $urandom_range(1, 8);
			else if (r < 95)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(60, 68);
			send_run(len);
		end
		wait_drained();
	endtask

	// receiver: check every taken word against the oldest owed one, then pick
	// the next stall, honoring a long hold when one is asked for
	always @(posedge clk) begin : sorted_check
		out_word_t want;
		if (dst_valid && !dst_stall) begin
			if (sorted_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, value %0d end %0b overflow %0b", $time,
					dst_word.sorted_value, dst_word.end_of_run, dst_word.overflow);
			end else begin
				want = sorted_expected.pop_front();
				words_checked++;
				if (dst_word.sorted_value !== want.sorted_value)
					flag_mismatch("sorted_value", want.sorted_value, dst_word.sorted_value);
				if (dst_word.end_of_run !== want.end_of_run)
					flag_mismatch("end_of_run", WORD_W'(want.end_of_run),
						WORD_W'(dst_word.end_of_run));
				if (dst_word.overflow !== want.overflow)
					flag_mismatch("overflow", WORD_W'(want.overflow),
						WORD_W'(dst_word.overflow));
			end
		end
		if (long_hold_req && hold_left == 0) begin
			hold_left     = LONG_HOLD;
			long_hold_req = 1'b0;
			holds_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			dst_stall <= 1'b1;
		end else begin
			dst_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// watchdog: too long with no word moving on either side ends the simulation
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d sorted words still owed",
					$time, idle_cycles, sorted_expected.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			offer_word(DIRECTED[i].word, DIRECTED[i].known, DIRECTED[i].typed);
			if (DIRECTED[i].word.is_last)
				runs_sent++;
		end
		wait_drained();

		// receiver idles more than sender, opening with one word past the store
		// so the last word itself is dropped
		run_phase(30, 56, DEPTH + 1, 1'b0);
		// roles swapped, opening with a run that fills the store exactly
		run_phase(56, 30, DEPTH, 1'b0);
		// no idling, a run well past the store, and one long receiver hold
		run_phase(0, 0, $urandom_range(DEPTH + 2, DEPTH + 16), 1'b1);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sorted_expected.size() != 0) begin
			errors++;
			$display("%0t: %0d sorted words never came out", $time, sorted_expected.size());
		end

		$display("covered %0d runs from %0d words in, %0d sorted words checked",
			runs_sent, words_sent, words_checked);
		$display("%0d runs overflowed the %0d-entry store, longest run %0d, %0d long holds",
			overflow_runs, DEPTH, longest_run, holds_done);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
